// ----- hdl/mm_pkg.sv -----
`default_nettype none
package mm_pkg;

	// Sizing
	localparam int MAX_DIM     = 8;
	localparam int FRAC_BITS   = 16;
	localparam int DIM_CAP     = (MAX_DIM < 8) ? MAX_DIM : 8;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int IDX_W       = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
	localparam int DIM_W       = $clog2(DIM_CAP + 1);
	localparam int PROD_W      = 64;
	localparam int ACC_W       = PROD_W + $clog2(DIM_CAP) + 1;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	// Field widths
	localparam int FUNC_W = 2;
	localparam int POS_W  = 3;
	localparam int VAL_W  = 32;
	localparam int CFG_W  = 4;
	localparam int CFG_IW = 2;

	// func codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IW-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IW-1:0] REG_COLS_B    = 2'd2;

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	typedef enum logic [1:0] {
		K_LOAD_A,
		K_LOAD_B,
		K_COMPUTE
	} kind_t;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [POS_W-1:0]        row_index;
		logic [POS_W-1:0]        col_index;
		logic signed [VAL_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [POS_W-1:0]        out_row;
		logic [POS_W-1:0]        out_col;
		logic signed [VAL_W-1:0] out_value;
		logic                    last;
	} out_word_t;

	typedef struct packed {
		logic [DIM_W-1:0] m;
		logic [DIM_W-1:0] n;
		logic [DIM_W-1:0] p;
	} dims_t;

	typedef struct packed {
		kind_t                kind;
		logic [STORE_AW-1:0]  addr;
		logic [VAL_W-1:0]     value;
	} entry_t;

	// 0 acts as 1, anything above the cap acts as the cap
	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (32'(v) > DIM_CAP)
			r = DIM_W'(DIM_CAP);
		else
			r = DIM_W'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/mm_front.sv -----
`default_nettype none
module mm_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire mm_pkg::in_word_t       cmd,
	input  wire                         full,
	input  wire                         wr_en,
	input  wire [mm_pkg::CFG_IW-1:0]    wr_index,
	input  wire [mm_pkg::CFG_W-1:0]     wr_data,
	output logic                        push,
	output mm_pkg::entry_t              entry,
	output mm_pkg::dims_t               dims
);
	import mm_pkg::*;

	logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic             accept, in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROWS_A:    rows_a_q    <= wr_data;
				REG_INNER_DIM: inner_dim_q <= wr_data;
				REG_COLS_B:    cols_b_q    <= wr_data;
				default: ;
			endcase
		end
	end

	assign dims.m = eff_dim(rows_a_q);
	assign dims.n = eff_dim(inner_dim_q);
	assign dims.p = eff_dim(cols_b_q);

	assign accept   = start && !full;
	assign in_range = (32'(cmd.row_index) < MAX_DIM) && (32'(cmd.col_index) < MAX_DIM);

	// classify; unused func and out-of-range loads are dropped here
	always_comb begin
		entry.addr  = STORE_AW'(cmd.row_index) * STORE_AW'(MAX_DIM) + STORE_AW'(cmd.col_index);
		entry.value = cmd.value;
		entry.kind  = K_COMPUTE;
		push        = 1'b0;
		case (cmd.func)
			FUNC_LOAD_A: begin
				entry.kind = K_LOAD_A;
				push       = accept && in_range;
			end
			FUNC_LOAD_B: begin
				entry.kind = K_LOAD_B;
				push       = accept && in_range;
			end
			FUNC_COMPUTE: begin
				entry.kind = K_COMPUTE;
				push       = accept;
			end
			default: push = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/mm_queue.sv -----
`default_nettype none
module mm_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire mm_pkg::entry_t  wr_entry,
	input  wire                  pop,
	output mm_pkg::entry_t       rd_entry,
	output logic                 full,
	output logic                 empty
);
	import mm_pkg::*;

	entry_t         slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full     = (count_q == (QAW+1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mm_back.sv -----
`default_nettype none
module mm_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire mm_pkg::entry_t  entry,
	input  wire                  empty,
	input  wire mm_pkg::dims_t   dims,
	output logic                 pop,
	output logic                 strobe,
	output mm_pkg::out_word_t    result
);
	import mm_pkg::*;

	typedef struct packed {
		logic             first;
		logic             dot_end;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tag_t;

	function automatic logic at_end(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] dim);
		return (DIM_W'(idx) + DIM_W'(1)) == dim;
	endfunction

	logic [VAL_W-1:0] mem_a [STORE_DEPTH];
	logic [VAL_W-1:0] mem_b [STORE_DEPTH];

	logic                    running_q;
	logic [IDX_W-1:0]        r_q, c_q, i_q;
	logic [STORE_AW-1:0]     addr_a, addr_b;
	logic                    i_end, c_end, r_end;
	tag_t                    tag_issue, tag_s1, tag_s2, tag_s3;
	logic                    v_s1, v_s2, v_s3;
	logic [VAL_W-1:0]        a_s1, b_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q, shifted;
	logic [VAL_W-1:0]        sat_value;
	logic                    strobe_q;
	out_word_t               result_q;

	assign pop = !running_q && !empty;

	assign addr_a = STORE_AW'(r_q) * STORE_AW'(MAX_DIM) + STORE_AW'(i_q);
	assign addr_b = STORE_AW'(i_q) * STORE_AW'(MAX_DIM) + STORE_AW'(c_q);

	assign i_end = at_end(i_q, dims.n);
	assign c_end = at_end(c_q, dims.p);
	assign r_end = at_end(r_q, dims.m);

	assign tag_issue.first   = (i_q == '0);
	assign tag_issue.dot_end = i_end;
	assign tag_issue.last    = i_end && c_end && r_end;
	assign tag_issue.row     = r_q;
	assign tag_issue.col     = c_q;

	// stores: one write port for loads, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (pop && entry.kind == K_LOAD_A)
			mem_a[entry.addr] <= entry.value;
		a_s1 <= mem_a[addr_a];
	end

	always_ff @(posedge clk) begin
		if (pop && entry.kind == K_LOAD_B)
			mem_b[entry.addr] <= entry.value;
		b_s1 <= mem_b[addr_b];
	end

	// index walk: i innermost, then column, then row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			r_q       <= '0;
			c_q       <= '0;
			i_q       <= '0;
		end else if (running_q) begin
			if (i_end) begin
				i_q <= '0;
				if (c_end) begin
					c_q <= '0;
					if (r_end)
						running_q <= 1'b0;
					else
						r_q <= r_q + IDX_W'(1);
				end else begin
					c_q <= c_q + IDX_W'(1);
				end
			end else begin
				i_q <= i_q + IDX_W'(1);
			end
		end else if (pop && entry.kind == K_COMPUTE) begin
			running_q <= 1'b1;
			r_q       <= '0;
			c_q       <= '0;
			i_q       <= '0;
		end
	end

	// MAC pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			v_s1     <= running_q;
			v_s2     <= v_s1;
			v_s3     <= v_s2 && tag_s2.dot_end;
			strobe_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= tag_issue;
		tag_s2  <= tag_s1;
		tag_s3  <= tag_s2;
		prod_s2 <= $signed(a_s1) * $signed(b_s1);
		if (v_s2)
			acc_q <= tag_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		result_q.out_row   <= POS_W'(tag_s3.row);
		result_q.out_col   <= POS_W'(tag_s3.col);
		result_q.out_value <= sat_value;
		result_q.last      <= tag_s3.last;
	end

	// floor shift, then clamp when the upper bits are not a sign extension
	always_comb begin
		shifted = acc_q >>> FRAC_BITS;
		if ((&shifted[ACC_W-1:VAL_W-1]) || !(|shifted[ACC_W-1:VAL_W-1]))
			sat_value = shifted[VAL_W-1:0];
		else if (shifted[ACC_W-1])
			sat_value = {1'b1, {(VAL_W-1){1'b0}}};
		else
			sat_value = {1'b0, {(VAL_W-1){1'b1}}};
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ----- hdl/matrix_multiply.sv -----
`default_nettype none
// Dense Q16.16 matrix product C = A x B. Load words (func 0 for A, 1 for B)
// write one element each and are taken one per cycle while busy is low;
// a compute word streams out C row-major, one word per strobe, with last set
// on the final element. The receiver cannot stall: each strobe is a single
// cycle and must be captured. Words pass through a 4-deep queue; busy goes
// high only when it is full, so loads following a compute wait in the queue.
// A compute runs one multiply-accumulate per cycle through the single read
// port of each store, rows_a * inner_dim * cols_b of them in all; each result
// sums inner_dim products through the read, product and accumulator registers
// to the output register. Elements never loaded read as garbage.
module matrix_multiply (
	input  wire                       clk,
	input  wire                       arst_n,
	// command side
	input  wire                       start,
	output logic                      busy,
	input  wire mm_pkg::in_word_t     cmd,
	// result side
	output logic                      strobe,
	output mm_pkg::out_word_t         result,
	// shape registers: rows_a, inner_dim, cols_b
	input  wire                       wr_en,
	input  wire [mm_pkg::CFG_IW-1:0]  wr_index,
	input  wire [mm_pkg::CFG_W-1:0]   wr_data
);
	import mm_pkg::*;

	entry_t push_entry, head_entry;
	dims_t  dims;
	logic   push, pop, full, empty;

	// front: shape registers and word classification
	mm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.full     (full),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.entry    (push_entry),
		.dims     (dims)
	);

	// decouples acceptance from the compute walk
	mm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.rd_entry (head_entry),
		.full     (full),
		.empty    (empty)
	);

	// back: element stores, index walk, MAC pipeline, output register
	mm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.entry  (head_entry),
		.empty  (empty),
		.dims   (dims),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

	assign busy = full;

endmodule
`default_nettype wire

// ----- hdl/mm_checker.sv -----
`default_nettype none
module mm_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     busy,
	input wire                     strobe,
	input wire mm_pkg::out_word_t  result
);
	import mm_pkg::*;

	// queue is empty right out of reset
	a_idle_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !busy)
		else $error("busy right after reset");

	// back-to-back words in one row step the column
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && $past(strobe) && !$past(result.last) &&
		(result.out_row == $past(result.out_row))
		|-> result.out_col == POS_W'($past(result.out_col) + POS_W'(1)))
		else $error("column did not step");

	// a row change starts the next row at column zero
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && $past(strobe) && !$past(result.last) &&
		(result.out_row != $past(result.out_row))
		|-> (result.out_row == POS_W'($past(result.out_row) + POS_W'(1))) &&
			(result.out_col == '0))
		else $error("row did not step");

	// a new product starts at the origin
	a_new_product: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && $past(strobe) && $past(result.last)
		|-> (result.out_row == '0) && (result.out_col == '0))
		else $error("product did not start at origin");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);
`default_nettype wire

// ----- tb/sv/tb_matrix_multiply.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the fixed-point matrix product block.
// Load words fill single elements of A and B; compute words stream C back,
// one word per strobe. A bench-side copy of both element stores and of the
// shape registers predicts every product word, and a checker compares each
// strobed word against the oldest prediction. The sender runs in bursts with
// random gaps. Shape writes happen only once the block has drained.
module tb_matrix_multiply;
	import mm_pkg::*;

	// unused encodings, kept as named codes
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [CFG_IW-1:0] REG_UNUSED  = 2'd3;

	localparam int SETTLE_CYCLES  = 16;   // load words can still sit in the input queue
	localparam int WATCHDOG_LIMIT = 4000; // cycles with no word moving on any port
	localparam int RANDOM_WORDS   = 200;
	localparam int SHOWN_FAILURES = 10;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_word_t          cmd;
	logic              strobe;
	out_word_t         result;
	logic              wr_en;
	logic [CFG_IW-1:0] wr_index;
	logic [CFG_W-1:0]  wr_data;

	matrix_multiply dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.strobe   (strobe),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: shadow copies of both stores, which entries were
	// ever loaded (never-loaded entries must not be read), and the shape.
	// ------------------------------------------------------------------
	logic signed [VAL_W-1:0] left_mat  [STORE_DEPTH];
	logic signed [VAL_W-1:0] right_mat [STORE_DEPTH];
	bit                      left_set  [STORE_DEPTH];
	bit                      right_set [STORE_DEPTH];
	logic [CFG_W-1:0]        rows_reg  = DIM_RESET;
	logic [CFG_W-1:0]        inner_reg = DIM_RESET;
	logic [CFG_W-1:0]        cols_reg  = DIM_RESET;

	out_word_t product_queue [$];  // predicted product words, oldest first

	int fail_count  = 0;
	int items_sent  = 0;
	int burst_left  = 0;
	int quiet_cycles = 0;

	// register value as the block uses it: 0 means 1, above the cap means the cap
	function automatic int clamp_dim(input logic [CFG_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (int'(raw) > DIM_CAP)
			return DIM_CAP;
		return int'(raw);
	endfunction

	// one element of C: exact products summed wide, floor shift, saturate
	function automatic logic signed [VAL_W-1:0] dot_fixed(input int r, input int c, input int n);
		logic signed [71:0] acc;
		logic signed [63:0] prod;
		logic signed [71:0] q;
		acc = '0;
		for (int i = 0; i < n; i++) begin
			prod = left_mat[r * MAX_DIM + i] * right_mat[i * MAX_DIM + c];
			acc  = acc + prod;
		end
		q = acc >>> FRAC_BITS;   // arithmetic shift rounds toward minus infinity
		if (q > 72'sd2147483647)
			return 32'sh7FFFFFFF;
		if (q < -72'sd2147483648)
			return 32'sh80000000;
		return q[VAL_W-1:0];
	endfunction

	function automatic void predict_product();
		int        m, n, p;
		out_word_t e;
		m = clamp_dim(rows_reg);
		n = clamp_dim(inner_reg);
		p = clamp_dim(cols_reg);
		for (int r = 0; r < m; r++) begin
			for (int c = 0; c < p; c++) begin
				e.out_row   = POS_W'(r);
				e.out_col   = POS_W'(c);
				e.out_value = dot_fixed(r, c, n);
				e.last      = (r == m - 1) && (c == p - 1);
				product_queue.push_back(e);
			end
		end
	endfunction

	// apply one accepted command word to the shadow state
	function automatic void track_word(input in_word_t w);
		int addr;
		addr = int'(w.row_index) * MAX_DIM + int'(w.col_index);
		case (w.func)
			FUNC_LOAD_A: begin
				left_mat[addr] = w.value;
				left_set[addr] = 1'b1;
			end
			FUNC_LOAD_B: begin
				right_mat[addr] = w.value;
				right_set[addr] = 1'b1;
			end
			FUNC_COMPUTE: begin
				predict_product();
			end
			default: begin
			end
		endcase
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= SHOWN_FAILURES)
			$display("%s", what);
	endtask

	// ------------------------------------------------------------------
	// Result checker: every strobe must match the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_products
		out_word_t want;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			if (product_queue.size() == 0) begin
				note_failure($sformatf("unexpected product word: row %0d col %0d value %h last %b",
					result.out_row, result.out_col, result.out_value, result.last));
			end else begin
				want = product_queue.pop_front();
				if (result !== want)
					note_failure($sformatf({"product word mismatch: expected row %0d col %0d ",
						"value %h last %b, got row %0d col %0d value %h last %b"},
						want.out_row, want.out_col, want.out_value, want.last,
						result.out_row, result.out_col, result.out_value, result.last));
			end
		end
	end

	// Watchdog: nothing accepted, strobed or written for too long means a hang.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (start && busy === 1'b0) || strobe === 1'b1 || wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Bursts of back-to-back words with random gaps between them; some
	// bursts are long so that stretches without any idling occur too.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 9)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(0, 6);
		end
	endtask

	// Send one command word and wait until the block takes it. start stays
	// high across back-to-back words; only pace() or a drain lowers it.
	task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] row,
	                        input logic [POS_W-1:0] col, input logic signed [VAL_W-1:0] value);
		in_word_t w;
		w.func      = func;
		w.row_index = row;
		w.col_index = col;
		w.value     = value;
		@(negedge clk);
		start <= 1'b1;
		cmd   <= w;
		do @(posedge clk); while (busy !== 1'b0);
		track_word(w);
		if (func != FUNC_UNUSED)
			items_sent++;
		pace();
	endtask

	// Stop sending and hold off until every predicted word has come back,
	// then give queued load words time to land.
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (product_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only call with the block idle.
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			REG_ROWS_A:    rows_reg  = data;
			REG_INNER_DIM: inner_reg = data;
			REG_COLS_B:    cols_reg  = data;
			default: begin
			end
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_shape(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] n,
	                         input logic [CFG_W-1:0] p);
		wait_idle();
		write_reg(REG_ROWS_A, m);
		write_reg(REG_INNER_DIM, n);
		write_reg(REG_COLS_B, p);
	endtask

	// Mix of saturating extremes, small Q16.16 numbers and raw random words.
	function automatic logic signed [VAL_W-1:0] pick_value();
		logic signed [VAL_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'sh7FFFFFFF;
			1: v = 32'sh80000000;
			2, 3, 4, 5: begin
				v = $urandom_range(0, 32'h80000);
				v = v - 32'sh40000;   // roughly -4.0 .. +4.0
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Load any element the current shape reads but that was never written,
	// then issue the compute word with junk in its ignored fields.
	task automatic run_product();
		int m, n, p;
		m = clamp_dim(rows_reg);
		n = clamp_dim(inner_reg);
		p = clamp_dim(cols_reg);
		for (int r = 0; r < m; r++)
			for (int i = 0; i < n; i++)
				if (!left_set[r * MAX_DIM + i])
					send_cmd(FUNC_LOAD_A, POS_W'(r), POS_W'(i), pick_value());
		for (int i = 0; i < n; i++)
			for (int c = 0; c < p; c++)
				if (!right_set[i * MAX_DIM + c])
					send_cmd(FUNC_LOAD_B, POS_W'(i), POS_W'(c), pick_value());
		send_cmd(FUNC_COMPUTE, POS_W'($urandom), POS_W'($urandom), $urandom);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Shape registers come out of reset at 8 x 8 x 8.
	task automatic test_reset_shape();
		run_product();
	endtask

	// Single-term products at the value extremes: both saturation
	// directions, floor rounding of a negative product, and zero.
	task automatic test_value_extremes();
		set_shape(4'd1, 4'd1, 4'd1);
		send_cmd(FUNC_LOAD_A, '0, '0, 32'sh7FFFFFFF);
		send_cmd(FUNC_LOAD_B, '0, '0, 32'sh7FFFFFFF);
		run_product();                                   // positive saturation
		send_cmd(FUNC_LOAD_B, '0, '0, 32'sh80000000);
		run_product();                                   // negative saturation
		send_cmd(FUNC_LOAD_A, '0, '0, 32'sh80000000);
		run_product();                                   // min * min
		send_cmd(FUNC_LOAD_A, '0, '0, -32'sd1);
		send_cmd(FUNC_LOAD_B, '0, '0, 32'sd1);
		run_product();                                   // tiny negative floors to -1 lsb
		send_cmd(FUNC_LOAD_A, '0, '0, 32'sd0);
		run_product();
	endtask

	// Register values 0 and above the cap, plus a write to the spare index.
	task automatic test_shape_clamp();
		set_shape(4'd0, 4'd15, 4'd9);
		run_product();
		set_shape(4'd15, 4'd0, 4'd0);
		run_product();
		wait_idle();
		write_reg(REG_UNUSED, 4'd5);
		run_product();
	endtask

	// Loads beyond the current shape still land; unused func does nothing.
	task automatic test_outside_shape();
		set_shape(4'd2, 4'd2, 4'd2);
		send_cmd(FUNC_LOAD_A, 3'd7, 3'd7, pick_value());
		send_cmd(FUNC_LOAD_B, 3'd7, 3'd7, pick_value());
		send_cmd(FUNC_UNUSED, 3'd5, 3'd2, $urandom);
		run_product();
		set_shape(4'd8, 4'd8, 4'd8);
		run_product();
	endtask

	function automatic logic [CFG_W-1:0] random_dim();
		case ($urandom_range(0, 9))
			0:       return CFG_W'($urandom_range(0, 15));
			1:       return CFG_W'(DIM_CAP);
			default: return CFG_W'($urandom_range(1, 3));
		endcase
	endfunction

	// Mostly well-formed load-then-compute sequences on small shapes, with
	// stray loads anywhere and unused-func noise mixed in.
	task automatic test_random_products();
		int goal;
		int m, n, p;
		goal = items_sent + RANDOM_WORDS;
		while (items_sent < goal) begin
			set_shape(random_dim(), random_dim(), random_dim());
			m = clamp_dim(rows_reg);
			n = clamp_dim(inner_reg);
			p = clamp_dim(cols_reg);
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 12)) begin
					case ($urandom_range(0, 19))
						0: send_cmd(FUNC_UNUSED, POS_W'($urandom), POS_W'($urandom), $urandom);
						1: send_cmd(FUNC_LOAD_A, POS_W'($urandom), POS_W'($urandom), pick_value());
						2: send_cmd(FUNC_LOAD_B, POS_W'($urandom), POS_W'($urandom), pick_value());
						default: begin
							if ($urandom_range(0, 1))
								send_cmd(FUNC_LOAD_A, POS_W'($urandom_range(0, m - 1)),
									POS_W'($urandom_range(0, n - 1)), pick_value());
							else
								send_cmd(FUNC_LOAD_B, POS_W'($urandom_range(0, n - 1)),
									POS_W'($urandom_range(0, p - 1)), pick_value());
						end
					endcase
				end
				run_product();
			end
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		cmd      = '0;
		wr_en    = 1'b0;
		wr_index = '0;
		wr_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_shape();
		test_value_extremes();
		test_shape_clamp();
		test_outside_shape();
		test_random_products();

		// drain, then let the pipeline run dry
		wait_idle();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
